// File: hw/rtl/rvb_pkg.sv
// Shared constants, register codes and arithmetic helpers of the reverb.
`timescale 1ns / 1ps
package rvb_pkg;

  localparam int COMB_COUNT_DEF        = 8;
  localparam int ALLPASS_COUNT_DEF     = 4;
  localparam int STEREO_OFFSET_DEF     = 23;
  localparam int COMB_DELAY_MAX_DEF    = 2048;
  localparam int ALLPASS_DELAY_MAX_DEF = 1024;
  localparam int SAMPLE_BITS_DEF       = 24;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 18;

  localparam logic [16:0] Q_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_GAIN    = 4'd0,
    REG_COMB_FEEDBACK = 4'd1,
    REG_DAMP_AMOUNT   = 4'd2,
    REG_WET_MAIN      = 4'd3,
    REG_WET_CROSS     = 4'd4,
    REG_DRY_LEVEL     = 4'd5,
    REG_MONO_MODE     = 4'd6,
    REG_FREEZE        = 4'd7
  } cfg_reg_e;

  function automatic logic [12:0] comb_tune(input logic [2:0] t);
    case (t)
      3'd0: comb_tune = 13'd1116;
      3'd1: comb_tune = 13'd1188;
      3'd2: comb_tune = 13'd1277;
      3'd3: comb_tune = 13'd1356;
      3'd4: comb_tune = 13'd1422;
      3'd5: comb_tune = 13'd1491;
      3'd6: comb_tune = 13'd1557;
      3'd7: comb_tune = 13'd1617;
      default: comb_tune = '0;
    endcase
  endfunction

  function automatic logic [9:0] ap_tune(input logic [1:0] t);
    case (t)
      2'd0: ap_tune = 10'd556;
      2'd1: ap_tune = 10'd441;
      2'd2: ap_tune = 10'd341;
      2'd3: ap_tune = 10'd225;
      default: ap_tune = '0;
    endcase
  endfunction

  // round half up after the Q16 product: floor((v + 2^15) / 2^16)
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    rnd16 = (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// File: hw/rtl/rvb_if.sv
// Channel interfaces: input frames, output frames and register writes.
`timescale 1ns / 1ps
interface rvb_in_if import rvb_pkg::*; #(parameter int SW = SAMPLE_BITS_DEF);
  logic          valid;
  logic          ready;
  logic [SW-1:0] left_sample;
  logic [SW-1:0] right_sample;
  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface rvb_out_if import rvb_pkg::*; #(parameter int SW = SAMPLE_BITS_DEF);
  logic          valid;
  logic          ready;
  logic [SW-1:0] left_out;
  logic [SW-1:0] right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface rvb_cfg_if import rvb_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/stereo_comb_allpass_reverb.sv
// Stereo comb/allpass reverberator: sequencer, delay memories and mixer.
//
//  channel | dir | handshake     | payload
//  in_if   | in  | valid/ready   | left_sample, right_sample
//  out_if  | out | valid/ready   | left_out, right_out
//  cfg_if  | in  | valid/ready=1 | index, data
//
// Each item is worked through step by step, paced by the one shared multiplier
// and the single port of each delay memory.
// After reset a clearing pass zeroes the delay memories; no item is taken then.
// One item is in work at a time; the next is taken while a result waits in the output
// register. A stalled result only holds the block before it loads the next result.
`timescale 1ns / 1ps
module stereo_comb_allpass_reverb import rvb_pkg::*; #(
  parameter int COMB_COUNT        = COMB_COUNT_DEF,
  parameter int ALLPASS_COUNT     = ALLPASS_COUNT_DEF,
  parameter int STEREO_OFFSET     = STEREO_OFFSET_DEF,
  parameter int COMB_DELAY_MAX    = COMB_DELAY_MAX_DEF,
  parameter int ALLPASS_DELAY_MAX = ALLPASS_DELAY_MAX_DEF,
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rvb_in_if.sink    in_if,
  rvb_out_if.source out_if,
  rvb_cfg_if.sink   cfg_if
);

  localparam int SW        = SAMPLE_BITS;
  localparam int CMEM_DEPTH = 2 * COMB_COUNT * COMB_DELAY_MAX;
  localparam int AMEM_DEPTH = 2 * ALLPASS_COUNT * ALLPASS_DELAY_MAX;
  localparam int CLR_DEPTH = (CMEM_DEPTH > AMEM_DEPTH) ? CMEM_DEPTH : AMEM_DEPTH;
  localparam int CA_W      = $clog2(CMEM_DEPTH);
  localparam int AA_W      = $clog2(AMEM_DEPTH);
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int CP_W      = $clog2(COMB_DELAY_MAX);
  localparam int AP_W      = $clog2(ALLPASS_DELAY_MAX);
  localparam int CI_W      = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
  localparam int AI_W      = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
  localparam int SUM_W     = 33 + CI_W;
  localparam int MA_W      = 33;
  localparam int MB_W      = 19;
  localparam int PR_W      = MA_W + MB_W;
  localparam int ACC_W     = PR_W + 3;
  localparam logic signed [63:0] S_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] S_MIN = -S_MAX - 64'sd1;

  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_CLEAR = 17'h00002,
    ST_GAIN  = 17'h00004,
    ST_GSAT  = 17'h00008,
    ST_CRD   = 17'h00010,
    ST_CP1   = 17'h00020,
    ST_CP2   = 17'h00040,
    ST_CLP   = 17'h00080,
    ST_CP3   = 17'h00100,
    ST_CWR   = 17'h00200,
    ST_ARD   = 17'h00400,
    ST_AWR   = 17'h00800,
    ST_MX1   = 17'h01000,
    ST_MX2   = 17'h02000,
    ST_MX3   = 17'h04000,
    ST_MXS   = 17'h08000,
    ST_OUT   = 17'h10000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [17:0] gain_q, wet_main_q, wet_cross_q, dry_q;
  logic [16:0] comb_fb_q, damp_q;
  logic        mono_q, freeze_q;

  // control
  logic              side_q;
  logic [CI_W-1:0]   ci_q;
  logic [AI_W-1:0]   ai_q;
  logic [CA_W-1:0]   cbase_q;
  logic [AA_W-1:0]   abase_q;
  logic [CLR_W-1:0]  clr_q;
  logic              ovalid_q;
  logic [CP_W-1:0]   cpos_q [2][COMB_COUNT];
  logic [AP_W-1:0]   apos_q [2][ALLPASS_COUNT];
  logic signed [31:0] lp_q  [2][COMB_COUNT];

  // datapath
  logic signed [SW-1:0]    raw_l_q, raw_r_q;
  logic signed [31:0]      x_q, cout_q, v_q, vl_q, vr_q;
  logic signed [PR_W-1:0]  prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SW-1:0]           res_l_q, res_r_q, out_l_q, out_r_q;

  // memories
  logic signed [31:0] cmem [CMEM_DEPTH];
  logic signed [31:0] amem [AMEM_DEPTH];
  logic signed [31:0] crd_q, ard_q;

  logic        accept;
  logic [16:0] fb_eff, d1_eff, d1_inv;
  assign accept = in_if.valid && in_if.ready;
  assign fb_eff = freeze_q ? Q_ONE : ((comb_fb_q > Q_ONE) ? Q_ONE : comb_fb_q);
  assign d1_eff = freeze_q ? '0 : ((damp_q > Q_ONE) ? Q_ONE : damp_q);
  assign d1_inv = Q_ONE - d1_eff;

  // delay lengths and positions
  logic [CI_W+2:0]  ci_ext;
  logic [AI_W+1:0]  ai_ext;
  logic [13:0]      ctune, atune;
  logic [CP_W:0]    clen, cpos_inc;
  logic [AP_W:0]    alen, apos_inc;
  logic [CP_W-1:0]  cpos, cpos_nx;
  logic [AP_W-1:0]  apos, apos_nx;
  logic [CA_W-1:0]  caddr;
  logic [AA_W-1:0]  aaddr;

  assign ci_ext   = (CI_W + 3)'(ci_q);
  assign ai_ext   = (AI_W + 2)'(ai_q);
  assign ctune    = {1'b0, comb_tune(ci_ext[2:0])} + (side_q ? 14'(STEREO_OFFSET) : 14'd0);
  assign atune    = {4'b0, ap_tune(ai_ext[1:0])} + (side_q ? 14'(STEREO_OFFSET) : 14'd0);
  assign clen     = (ctune > 14'(COMB_DELAY_MAX)) ? (CP_W + 1)'(COMB_DELAY_MAX)
                                                  : (CP_W + 1)'(ctune);
  assign alen     = (atune > 14'(ALLPASS_DELAY_MAX)) ? (AP_W + 1)'(ALLPASS_DELAY_MAX)
                                                     : (AP_W + 1)'(atune);
  assign cpos     = cpos_q[side_q][ci_q];
  assign apos     = apos_q[side_q][ai_q];
  assign cpos_inc = {1'b0, cpos} + 1'b1;
  assign apos_inc = {1'b0, apos} + 1'b1;
  assign cpos_nx  = (cpos_inc == clen) ? '0 : cpos_inc[CP_W-1:0];
  assign apos_nx  = (apos_inc == alen) ? '0 : apos_inc[AP_W-1:0];
  assign caddr    = cbase_q + CA_W'(cpos);
  assign aaddr    = abase_q + AA_W'(apos);

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PR_W-1:0] prod;
  logic signed [31:0]     lp_cur;
  assign lp_cur = lp_q[side_q][ci_q];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_GAIN: begin
        mul_a = side_q ? MA_W'(raw_r_q) : MA_W'(raw_l_q);
        mul_b = $signed({1'b0, gain_q});
      end
      ST_CP1: begin
        mul_a = MA_W'(crd_q);
        mul_b = MB_W'($signed({1'b0, d1_inv}));
      end
      ST_CP2: begin
        mul_a = MA_W'(lp_cur);
        mul_b = MB_W'($signed({1'b0, d1_eff}));
      end
      ST_CP3: begin
        mul_a = MA_W'(lp_cur);
        mul_b = MB_W'($signed({1'b0, fb_eff}));
      end
      ST_MX1: begin
        mul_a = side_q ? MA_W'(vr_q) : MA_W'(vl_q);
        mul_b = $signed({1'b0, wet_main_q});
      end
      ST_MX2: begin
        mul_a = side_q ? MA_W'(vl_q) : MA_W'(vr_q);
        mul_b = $signed({1'b0, wet_cross_q});
      end
      ST_MX3: begin
        mul_a = side_q ? MA_W'(raw_r_q) : MA_W'(raw_l_q);
        mul_b = $signed({1'b0, dry_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // arithmetic of each step
  logic signed [31:0]      gsat, lp_new, cwdata, awdata, vnew, sum_sat;
  logic signed [SUM_W-1:0] sum_nx;
  logic signed [32:0]      half;
  logic signed [63:0]      mix;
  logic [SW-1:0]           mix_sat;

  assign gsat    = sat32(rnd16(64'(prod_q)));
  assign lp_new  = sat32(rnd16(64'(acc_q) + 64'(prod_q)));
  assign cwdata  = sat32(64'(x_q) + rnd16(64'(prod_q)));
  assign sum_nx  = sum_q + SUM_W'(cout_q);
  assign sum_sat = sat32(64'(sum_nx));
  assign half    = (33'(ard_q) + 33'sd1) >>> 1;
  assign awdata  = sat32(64'(v_q) + 64'(half));
  assign vnew    = sat32(64'(ard_q) - 64'(v_q));
  assign mix     = rnd16(64'(acc_q) + 64'(prod_q));
  assign mix_sat = (mix > S_MAX) ? SW'(S_MAX) : ((mix < S_MIN) ? SW'(S_MIN) : SW'(mix));

  logic comb_last, ap_last, clr_last;
  assign comb_last = (ci_q == CI_W'(COMB_COUNT - 1));
  assign ap_last   = (ai_q == AI_W'(ALLPASS_COUNT - 1));
  assign clr_last  = (clr_q == CLR_W'(CLR_DEPTH - 1));

  // memory ports
  logic              cmem_we, amem_we;
  logic [CA_W-1:0]   cmem_wa;
  logic [AA_W-1:0]   amem_wa;
  logic signed [31:0] cmem_wd, amem_wd;

  always_comb begin
    cmem_we = 1'b0;
    amem_we = 1'b0;
    cmem_wa = caddr;
    amem_wa = aaddr;
    cmem_wd = cwdata;
    amem_wd = awdata;
    if (state_q == ST_CLEAR) begin
      cmem_we = ((CLR_W + 1)'(clr_q) < (CLR_W + 1)'(CMEM_DEPTH));
      amem_we = ((CLR_W + 1)'(clr_q) < (CLR_W + 1)'(AMEM_DEPTH));
      cmem_wa = clr_q[CA_W-1:0];
      amem_wa = clr_q[AA_W-1:0];
      cmem_wd = '0;
      amem_wd = '0;
    end else begin
      cmem_we = (state_q == ST_CWR);
      amem_we = (state_q == ST_AWR);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmem_we) begin
      cmem[cmem_wa] <= cmem_wd;
    end
    if (state_q == ST_CRD) begin
      crd_q <= cmem[caddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (amem_we) begin
      amem[amem_wa] <= amem_wd;
    end
    if (state_q == ST_ARD) begin
      ard_q <= amem[aaddr];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_if.valid) state_d = ST_GAIN;
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_GAIN:  state_d = ST_GSAT;
      ST_GSAT:  state_d = ST_CRD;
      ST_CRD:   state_d = ST_CP1;
      ST_CP1:   state_d = ST_CP2;
      ST_CP2:   state_d = ST_CLP;
      ST_CLP:   state_d = ST_CP3;
      ST_CP3:   state_d = ST_CWR;
      ST_CWR:   state_d = comb_last ? ST_ARD : ST_CRD;
      ST_ARD:   state_d = ST_AWR;
      ST_AWR: begin
        if (!ap_last) begin
          state_d = ST_ARD;
        end else begin
          state_d = side_q ? ST_MX1 : ST_GAIN;
        end
      end
      ST_MX1:   state_d = ST_MX2;
      ST_MX2:   state_d = ST_MX3;
      ST_MX3:   state_d = ST_MXS;
      ST_MXS:   state_d = side_q ? ST_OUT : ST_MX1;
      ST_OUT:   if (!ovalid_q || out_if.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      side_q      <= 1'b0;
      ci_q        <= '0;
      ai_q        <= '0;
      cbase_q     <= '0;
      abase_q     <= '0;
      clr_q       <= '0;
      ovalid_q    <= 1'b0;
      gain_q      <= 18'd983;
      comb_fb_q   <= 17'd60555;
      damp_q      <= 17'd5243;
      wet_main_q  <= 18'd98304;
      wet_cross_q <= 18'd0;
      dry_q       <= 18'd65536;
      mono_q      <= 1'b0;
      freeze_q    <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < COMB_COUNT; i++) begin
          cpos_q[s][i] <= '0;
          lp_q[s][i]   <= '0;
        end
        for (int i = 0; i < ALLPASS_COUNT; i++) begin
          apos_q[s][i] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (cfg_if.valid) begin
        case (cfg_reg_e'(cfg_if.index))
          REG_INPUT_GAIN:    gain_q      <= cfg_if.data;
          REG_COMB_FEEDBACK: comb_fb_q   <= cfg_if.data[16:0];
          REG_DAMP_AMOUNT:   damp_q      <= cfg_if.data[16:0];
          REG_WET_MAIN:      wet_main_q  <= cfg_if.data;
          REG_WET_CROSS:     wet_cross_q <= cfg_if.data;
          REG_DRY_LEVEL:     dry_q       <= cfg_if.data;
          REG_MONO_MODE:     mono_q      <= cfg_if.data[0];
          REG_FREEZE:        freeze_q    <= cfg_if.data[0];
          default: ;
        endcase
      end
      if (out_if.ready && (state_q != ST_OUT)) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: clr_q <= clr_q + 1'b1;
        ST_IDLE: begin
          side_q  <= 1'b0;
          cbase_q <= '0;
          abase_q <= '0;
        end
        ST_GSAT: ci_q <= '0;
        ST_CLP:  lp_q[side_q][ci_q] <= lp_new;
        ST_CWR: begin
          cpos_q[side_q][ci_q] <= cpos_nx;
          cbase_q <= cbase_q + CA_W'(COMB_DELAY_MAX);
          ci_q    <= comb_last ? '0 : ci_q + 1'b1;
          ai_q    <= '0;
        end
        ST_AWR: begin
          apos_q[side_q][ai_q] <= apos_nx;
          abase_q <= abase_q + AA_W'(ALLPASS_DELAY_MAX);
          ai_q    <= ap_last ? '0 : ai_q + 1'b1;
          if (ap_last) side_q <= ~side_q;
        end
        ST_MXS: side_q <= ~side_q;
        ST_OUT: if (!ovalid_q || out_if.ready) ovalid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    case (state_q)
      ST_IDLE: begin
        raw_l_q <= in_if.left_sample;
        raw_r_q <= mono_q ? in_if.left_sample : in_if.right_sample;
      end
      ST_GSAT: begin
        x_q   <= gsat;
        sum_q <= '0;
      end
      ST_CP1: cout_q <= crd_q;
      ST_CP2: acc_q  <= ACC_W'(prod_q);
      ST_CWR: begin
        sum_q <= sum_nx;
        if (comb_last) v_q <= sum_sat;
      end
      ST_AWR: begin
        v_q <= vnew;
        if (ap_last) begin
          if (side_q) vr_q <= vnew;
          else        vl_q <= vnew;
        end
      end
      ST_MX2: acc_q <= ACC_W'(prod_q);
      ST_MX3: acc_q <= acc_q + ACC_W'(prod_q);
      ST_MXS: begin
        if (side_q) res_r_q <= mono_q ? '0 : mix_sat;
        else        res_l_q <= mix_sat;
      end
      ST_OUT: begin
        if (!ovalid_q || out_if.ready) begin
          out_l_q <= res_l_q;
          out_r_q <= res_r_q;
        end
      end
      default: ;
    endcase
  end

  assign in_if.ready      = (state_q == ST_IDLE);
  assign cfg_if.ready     = 1'b1;
  assign out_if.valid     = ovalid_q;
  assign out_if.left_out  = out_l_q;
  assign out_if.right_out = out_r_q;

endmodule

// File: hw/rtl/rvb_checker.sv
// Port-level checks of the reverb and their bind to the top level.
`timescale 1ns / 1ps
module rvb_checker import rvb_pkg::*; #(
  parameter int SW = SAMPLE_BITS_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [SW-1:0] out_left_i,
  input logic [SW-1:0] out_right_i
);

  // a taken item keeps the input closed for the next cycle
  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input open right after an item");

  // a new result only appears at the end of work, never from idle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_left_i) && $stable(out_right_i)))
    else $error("stalled result changed");

  a_out_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("result dropped");

endmodule

bind stereo_comb_allpass_reverb rvb_checker #(.SW(SAMPLE_BITS)) u_rvb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_left_i  (out_if.left_out),
  .out_right_i (out_if.right_out)
);
